// File: sv/ieas_pkg.sv
// Shared types, codes and constants of the I2C EEPROM access sequencer.
package ieas_pkg;

	localparam int PAGE_BYTES = 64;
	localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
	localparam int SEG_W      = 9;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Sequencer phases.
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_START  = 4'd1;
	localparam logic [3:0] PH_SLAW   = 4'd2;
	localparam logic [3:0] PH_AHI    = 4'd3;
	localparam logic [3:0] PH_ALO    = 4'd4;
	localparam logic [3:0] PH_RSTART = 4'd5;
	localparam logic [3:0] PH_SLAR   = 4'd6;
	localparam logic [3:0] PH_WDATA  = 4'd7;
	localparam logic [3:0] PH_RDATA  = 4'd8;

	// Item kinds.
	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_STATUS  = 1'b1;

	// Bus status codes reported by the controller.
	localparam logic [3:0] ST_START      = 4'd0;
	localparam logic [3:0] ST_REP_START  = 4'd1;
	localparam logic [3:0] ST_ARB_LOST   = 4'd2;
	localparam logic [3:0] ST_SLAW_ACK   = 4'd3;
	localparam logic [3:0] ST_SLAW_NACK  = 4'd4;
	localparam logic [3:0] ST_TXDATA_ACK = 4'd5;
	localparam logic [3:0] ST_TXDATA_NACK = 4'd6;
	localparam logic [3:0] ST_SLAR_ACK   = 4'd7;
	localparam logic [3:0] ST_SLAR_NACK  = 4'd8;
	localparam logic [3:0] ST_RXDATA_ACK = 4'd9;
	localparam logic [3:0] ST_RXDATA_NACK = 4'd10;

	// Bus commands.
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_START  = 3'd1;
	localparam logic [2:0] CMD_SEND   = 3'd2;
	localparam logic [2:0] CMD_RXACK  = 3'd3;
	localparam logic [2:0] CMD_RXNACK = 3'd4;
	localparam logic [2:0] CMD_STOP   = 3'd5;

	typedef struct packed {
		logic        action;
		logic        is_read;
		logic [15:0] start_address;
		logic [15:0] length;
		logic [3:0]  bus_status;
		logic [7:0]  rx_byte;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  bus_command;
		logic [7:0]  tx_byte;
		logic [15:0] want_index;
		logic        rx_valid;
		logic [7:0]  rx_data;
		logic [15:0] rx_index;
		logic        done_res;
		logic        failed;
		logic [15:0] byte_count;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [3:0]       phase;
		logic             read_mode;
		logic [15:0]      cur_addr;
		logic [15:0]      remaining;
		logic [SEG_W-1:0] seg_left;
		logic [15:0]      total_done;
	} seq_state_t;

endpackage

// File: sv/i2c_eeprom_access_sequencer_core.sv
// Top level of the I2C EEPROM access sequencer: input stage, state and result queue.
//
//  channel | signals                          | moves
//  in      | in_valid / in_ready              | one request or bus status item per transfer
//  out     | out_valid / out_ready            | one bus command result per transfer
//  cfg     | cfg_wr_en / cfg_wr_data          | device address write, no handshake
//
// An accepted item is registered, then evaluated in the next cycle; the result queue
// registers its results before they can be taken. One item per cycle is sustained while
// each gives one result and out_ready stays high; two results take two output transfers.
// The input register is released only while the four-entry result queue has room for two.
// Reset clears the state to idle and the device address to 80; there is no clearing pass.
module i2c_eeprom_access_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        is_read,
	input  logic [15:0] start_address,
	input  logic [15:0] length,
	input  logic [3:0]  bus_status,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  bus_command,
	output logic [7:0]  tx_byte,
	output logic [15:0] want_index,
	output logic        rx_valid,
	output logic [7:0]  rx_data,
	output logic [15:0] rx_index,
	output logic        done_res,
	output logic        failed,
	output logic [15:0] byte_count,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data
);

	logic                 valid_s1;
	ieas_pkg::item_t      item_s1;
	ieas_pkg::seq_state_t state_q;
	ieas_pkg::seq_state_t state_nxt;
	logic [6:0]           dev_addr_q;
	logic [1:0]           n_res;
	logic [1:0]           push_cnt;
	ieas_pkg::res_t       res0;
	ieas_pkg::res_t       res1;
	ieas_pkg::res_t       head;
	logic                 room;
	logic                 consume;

	assign consume  = valid_s1 && room;
	assign in_ready = !valid_s1 || consume;
	assign push_cnt = consume ? n_res : 2'd0;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action        <= action;
			item_s1.is_read       <= is_read;
			item_s1.start_address <= start_address;
			item_s1.length        <= length;
			item_s1.bus_status    <= bus_status;
			item_s1.rx_byte       <= rx_byte;
			item_s1.write_byte    <= write_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			state_q    <= '0;
			dev_addr_q <= 7'd80;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				state_q <= state_nxt;
			end
			if (cfg_wr_en) begin
				dev_addr_q <= cfg_wr_data;
			end
		end
	end

	ieas_step u_step (
		.st       (state_q),
		.item     (item_s1),
		.dev_addr (dev_addr_q),
		.nxt      (state_nxt),
		.n_res    (n_res),
		.res0     (res0),
		.res1     (res1)
	);

	ieas_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.din0       (res0),
		.din1       (res1),
		.room       (room),
		.dout_valid (out_valid),
		.dout_ready (out_ready),
		.dout       (head)
	);

	assign bus_command = head.bus_command;
	assign tx_byte     = head.tx_byte;
	assign want_index  = head.want_index;
	assign rx_valid    = head.rx_valid;
	assign rx_data     = head.rx_data;
	assign rx_index    = head.rx_index;
	assign done_res    = head.done_res;
	assign failed      = head.failed;
	assign byte_count  = head.byte_count;
	assign last        = head.last;

endmodule

// File: sv/ieas_step.sv
// Next-state and result logic of the sequencer for one item.
module ieas_step (
	input  ieas_pkg::seq_state_t st,
	input  ieas_pkg::item_t      item,
	input  logic [6:0]           dev_addr,
	output ieas_pkg::seq_state_t nxt,
	output logic [1:0]           n_res,
	output ieas_pkg::res_t       res0,
	output ieas_pkg::res_t       res1
);

	logic [2:0]  cmd;
	logic [7:0]  tx;
	logic        rxv;
	logic        done;
	logic        fail;
	logic        two;
	logic        none;
	logic [15:0] rem_dec;
	logic [ieas_pkg::SEG_W-1:0] seg_dec;
	logic [15:0] want;
	logic [7:0]  sla_w;
	logic [7:0]  sla_r;

	// Bytes left in the page that holds addr, capped by the bytes still to go.
	function automatic logic [ieas_pkg::SEG_W-1:0] page_room(input logic [15:0] addr,
		input logic [15:0] rem);
		logic [ieas_pkg::SEG_W-1:0] room;
		room = ieas_pkg::SEG_W'(ieas_pkg::PAGE_BYTES)
			- ieas_pkg::SEG_W'(addr[ieas_pkg::PAGE_BITS-1:0]);
		if (rem < 16'(room)) begin
			return rem[ieas_pkg::SEG_W-1:0];
		end
		return room;
	endfunction

	assign sla_w   = {dev_addr, 1'b0};
	assign sla_r   = {dev_addr, 1'b1};
	assign rem_dec = st.remaining - 16'd1;
	assign seg_dec = st.seg_left - ieas_pkg::SEG_W'(1);

	always_comb begin
		nxt  = st;
		cmd  = ieas_pkg::CMD_NONE;
		tx   = 8'd0;
		rxv  = 1'b0;
		done = 1'b0;
		fail = 1'b0;
		two  = 1'b0;
		none = 1'b0;
		if (item.action == ieas_pkg::ACT_REQUEST) begin
			if (st.phase != ieas_pkg::PH_IDLE) begin
				none = 1'b1;
			end else begin
				nxt.read_mode  = item.is_read;
				nxt.cur_addr   = item.start_address;
				nxt.remaining  = item.length;
				nxt.total_done = 16'd0;
				nxt.seg_left   = item.is_read ? '0
					: page_room(item.start_address, item.length);
				nxt.phase      = ieas_pkg::PH_START;
				cmd            = ieas_pkg::CMD_START;
			end
		end else begin
			case (st.phase)
				ieas_pkg::PH_START: begin
					if (item.bus_status inside {ieas_pkg::ST_START, ieas_pkg::ST_REP_START}) begin
						nxt.phase = ieas_pkg::PH_SLAW;
						cmd = ieas_pkg::CMD_SEND;
						tx = sla_w;
					end else if (item.bus_status == ieas_pkg::ST_ARB_LOST) begin
						nxt.phase = ieas_pkg::PH_START;
						cmd = ieas_pkg::CMD_START;
					end else begin
						// No stop goes out while the start itself is in doubt.
						nxt.phase = ieas_pkg::PH_IDLE;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				ieas_pkg::PH_SLAW: begin
					if (item.bus_status == ieas_pkg::ST_SLAW_ACK) begin
						nxt.phase = ieas_pkg::PH_AHI;
						cmd = ieas_pkg::CMD_SEND;
						tx = st.cur_addr[15:8];
					end else if (item.bus_status inside {ieas_pkg::ST_SLAW_NACK,
						ieas_pkg::ST_ARB_LOST}) begin
						nxt.phase = ieas_pkg::PH_START;
						cmd = ieas_pkg::CMD_START;
					end else begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				ieas_pkg::PH_AHI, ieas_pkg::PH_ALO: begin
					if (item.bus_status == ieas_pkg::ST_TXDATA_ACK) begin
						if (st.phase == ieas_pkg::PH_AHI) begin
							nxt.phase = ieas_pkg::PH_ALO;
							cmd = ieas_pkg::CMD_SEND;
							tx = st.cur_addr[7:0];
						end else if (st.read_mode) begin
							nxt.phase = ieas_pkg::PH_RSTART;
							cmd = ieas_pkg::CMD_START;
						end else if (st.seg_left != '0) begin
							nxt.phase = ieas_pkg::PH_WDATA;
							cmd = ieas_pkg::CMD_SEND;
							tx = item.write_byte;
						end else begin
							nxt.phase = ieas_pkg::PH_IDLE;
							cmd = ieas_pkg::CMD_STOP;
							done = 1'b1;
						end
					end else if (item.bus_status == ieas_pkg::ST_TXDATA_NACK) begin
						if (st.read_mode) begin
							nxt.phase = ieas_pkg::PH_IDLE;
							cmd = ieas_pkg::CMD_STOP;
							done = 1'b1;
						end else begin
							// Retry the page: stop now, start again.
							nxt.phase = ieas_pkg::PH_START;
							two = 1'b1;
						end
					end else if (item.bus_status == ieas_pkg::ST_ARB_LOST) begin
						nxt.phase = ieas_pkg::PH_START;
						cmd = ieas_pkg::CMD_START;
					end else begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				ieas_pkg::PH_RSTART: begin
					if (item.bus_status inside {ieas_pkg::ST_START, ieas_pkg::ST_REP_START}) begin
						nxt.phase = ieas_pkg::PH_SLAR;
						cmd = ieas_pkg::CMD_SEND;
						tx = sla_r;
					end else if (item.bus_status == ieas_pkg::ST_ARB_LOST) begin
						nxt.phase = ieas_pkg::PH_START;
						cmd = ieas_pkg::CMD_START;
					end else begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				ieas_pkg::PH_SLAR: begin
					if (item.bus_status == ieas_pkg::ST_SLAR_ACK) begin
						if (st.remaining == 16'd0) begin
							nxt.phase = ieas_pkg::PH_IDLE;
							cmd = ieas_pkg::CMD_STOP;
							done = 1'b1;
						end else begin
							nxt.phase = ieas_pkg::PH_RDATA;
							cmd = (st.remaining == 16'd1) ? ieas_pkg::CMD_RXNACK
								: ieas_pkg::CMD_RXACK;
						end
					end else if (item.bus_status == ieas_pkg::ST_SLAR_NACK) begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
					end else if (item.bus_status == ieas_pkg::ST_ARB_LOST) begin
						nxt.phase = ieas_pkg::PH_START;
						cmd = ieas_pkg::CMD_START;
					end else begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				ieas_pkg::PH_RDATA: begin
					if ((item.bus_status inside {ieas_pkg::ST_RXDATA_ACK,
						ieas_pkg::ST_RXDATA_NACK}) && st.remaining != 16'd0) begin
						nxt.total_done = st.total_done + 16'd1;
						nxt.cur_addr   = st.cur_addr + 16'd1;
						nxt.remaining  = rem_dec;
						rxv = 1'b1;
						if (item.bus_status == ieas_pkg::ST_RXDATA_NACK || rem_dec == 16'd0) begin
							nxt.phase = ieas_pkg::PH_IDLE;
							cmd = ieas_pkg::CMD_STOP;
							done = 1'b1;
						end else begin
							cmd = (rem_dec == 16'd1) ? ieas_pkg::CMD_RXNACK
								: ieas_pkg::CMD_RXACK;
						end
					end else begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				ieas_pkg::PH_WDATA: begin
					if (item.bus_status == ieas_pkg::ST_TXDATA_ACK && st.seg_left != '0
						&& st.remaining != 16'd0) begin
						nxt.total_done = st.total_done + 16'd1;
						nxt.cur_addr   = st.cur_addr + 16'd1;
						nxt.remaining  = rem_dec;
						nxt.seg_left   = seg_dec;
						if (seg_dec != '0) begin
							cmd = ieas_pkg::CMD_SEND;
							tx = item.write_byte;
						end else if (rem_dec != 16'd0) begin
							// Page boundary: close this page and open the next one.
							nxt.seg_left = page_room(st.cur_addr + 16'd1, rem_dec);
							nxt.phase = ieas_pkg::PH_START;
							two = 1'b1;
						end else begin
							nxt.phase = ieas_pkg::PH_IDLE;
							cmd = ieas_pkg::CMD_STOP;
							done = 1'b1;
						end
					end else begin
						nxt.phase = ieas_pkg::PH_IDLE;
						cmd = ieas_pkg::CMD_STOP;
						done = 1'b1;
						fail = 1'b1;
					end
				end
				default: begin
					nxt.phase = ieas_pkg::PH_IDLE;
					none = 1'b1;
				end
			endcase
		end
	end

	assign want = nxt.total_done + ((nxt.phase == ieas_pkg::PH_WDATA) ? 16'd1 : 16'd0);

	always_comb begin
		res0 = '0;
		res1 = '0;
		res0.want_index = want;
		res0.byte_count = nxt.total_done;
		res1.want_index = want;
		res1.byte_count = nxt.total_done;
		if (two) begin
			res0.bus_command = ieas_pkg::CMD_STOP;
			res1.bus_command = ieas_pkg::CMD_START;
			res1.last = 1'b1;
		end else begin
			res0.bus_command = cmd;
			res0.tx_byte     = tx;
			res0.rx_valid    = rxv;
			res0.rx_data     = rxv ? item.rx_byte : 8'd0;
			res0.rx_index    = rxv ? st.total_done : 16'd0;
			res0.done_res    = done;
			res0.failed      = fail;
			res0.last        = 1'b1;
		end
		if (none) begin
			n_res = 2'd0;
		end else if (two) begin
			n_res = 2'd2;
		end else begin
			n_res = 2'd1;
		end
	end

endmodule

// File: sv/ieas_res_fifo.sv
// Result queue that takes up to two results per cycle and delivers one.
module ieas_res_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_cnt,
	input  ieas_pkg::res_t  din0,
	input  ieas_pkg::res_t  din1,
	output logic            room,
	output logic            dout_valid,
	input  logic            dout_ready,
	output ieas_pkg::res_t  dout
);

	ieas_pkg::res_t mem_q [ieas_pkg::FIFO_DEPTH];
	logic [ieas_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [ieas_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [ieas_pkg::FIFO_CW-1:0] count_q;
	logic pop;

	assign dout_valid = (count_q != '0);
	assign pop        = dout_valid && dout_ready;
	assign dout       = mem_q[rd_ptr_q];
	// Room for two more results without looking at the pop.
	assign room = (count_q <= ieas_pkg::FIFO_CW'(ieas_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + ieas_pkg::FIFO_AW'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ieas_pkg::FIFO_AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ieas_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + ieas_pkg::FIFO_CW'(push_cnt)
				- ieas_pkg::FIFO_CW'(pop);
		end
	end

endmodule

// File: sv/ieas_checker.sv
// Port-level checks of the sequencer, bound to the top level.
module ieas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  bus_command,
	input logic [7:0]  tx_byte,
	input logic        rx_valid,
	input logic [7:0]  rx_data,
	input logic [15:0] rx_index,
	input logic        done_res,
	input logic        failed,
	input logic        last
);

	// A stalled result keeps its command and its last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bus_command) && $stable(last))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> done_res)
		else $error("failure reported without done");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_command != ieas_pkg::CMD_SEND |-> tx_byte == 8'd0)
		else $error("tx byte set without a send command");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_valid |-> rx_data == 8'd0 && rx_index == 16'd0)
		else $error("receive fields set without a delivered byte");

	// A finished request always closes its result group.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> last)
		else $error("done result not marked last");

endmodule

bind i2c_eeprom_access_sequencer_core ieas_checker u_ieas_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.bus_command (bus_command),
	.tx_byte     (tx_byte),
	.rx_valid    (rx_valid),
	.rx_data     (rx_data),
	.rx_index    (rx_index),
	.done_res    (done_res),
	.failed      (failed),
	.last        (last)
);
